// File: hdl/current_auto_range_switch_defines.svh
// Assertion macros for the current auto-range switch.
// Used by the top level only; no other dependencies.
`ifndef CURRENT_AUTO_RANGE_SWITCH_DEFINES_SVH
`define CURRENT_AUTO_RANGE_SWITCH_DEFINES_SVH

`ifndef SYNTH
`define CARSW_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
	else $error("carsw: check failed");
`define CARSW_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("carsw: implication failed");
`else
`define CARSW_ASSERT(lbl, ck, rn, prop)
`define CARSW_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`endif

`endif

// File: hdl/carsw_pkg.sv
// Shared types and constants for the current auto-range switch.
// No dependencies.
`default_nettype none

package carsw_pkg;

	localparam int unsigned SAMPLE_W = 24;
	localparam int unsigned MAG_W    = 23;
	localparam int unsigned RUN_W    = 8;
	localparam int unsigned CAL_W    = 16;
	localparam int unsigned TOTAL_W  = 32;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 5;

	localparam logic [MAG_W-1:0] MAG_MAX = '1;
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	localparam logic             RST_AUTO_EN    = 1'b1;
	localparam logic [MAG_W-1:0] RST_NARROW_THR = 23'd67109;
	localparam logic [MAG_W-1:0] RST_WIDE_THR   = 23'd26844;
	localparam logic [MAG_W-1:0] RST_EMG_THR    = 23'd30199;
	localparam logic [RUN_W-1:0] RST_LOW_RUNS   = 8'd10;
	localparam logic [RUN_W-1:0] RST_HIGH_RUNS  = 8'd3;
	localparam logic [RUN_W-1:0] RST_EMG_RUNS   = 8'd1;
	localparam logic [CAL_W-1:0] RST_BASE_CAL   = 16'd4096;

	typedef enum logic [2:0] {
		REG_AUTO_EN    = 3'd0,
		REG_NARROW_THR = 3'd1,
		REG_WIDE_THR   = 3'd2,
		REG_EMG_THR    = 3'd3,
		REG_LOW_RUNS   = 3'd4,
		REG_HIGH_RUNS  = 3'd5,
		REG_EMG_RUNS   = 3'd6,
		REG_BASE_CAL   = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_NARROW = 3'd1,
		EV_WIDE   = 3'd2,
		EV_EMERG  = 3'd3,
		EV_REJECT = 3'd4
	} event_t;

	localparam logic RANGE_WIDE   = 1'b0;
	localparam logic RANGE_NARROW = 1'b1;

	typedef struct packed {
		logic             auto_enable;
		logic [MAG_W-1:0] to_narrow_threshold;
		logic [MAG_W-1:0] to_wide_threshold;
		logic [MAG_W-1:0] emergency_threshold;
		logic [RUN_W-1:0] low_runs_needed;
		logic [RUN_W-1:0] high_runs_needed;
		logic [RUN_W-1:0] emergency_runs_needed;
	} cfg_t;

	typedef struct packed {
		logic             load;
		logic [CAL_W-1:0] value;
	} cal_wr_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] current_sample;
	} sample_t;

	typedef struct packed {
		logic               adc_range;
		logic [CAL_W-1:0]   shunt_cal_value;
		event_t             switch_event;
		logic [TOTAL_W-1:0] narrow_switch_total;
		logic [TOTAL_W-1:0] wide_switch_total;
		logic [TOTAL_W-1:0] emergency_total;
	} result_t;

	typedef struct packed {
		logic               range_sel;
		logic [CAL_W-1:0]   cal_now;
		logic [RUN_W-1:0]   low_run;
		logic [RUN_W-1:0]   high_run;
		logic [RUN_W-1:0]   emg_run;
		logic [TOTAL_W-1:0] narrow_cnt;
		logic [TOTAL_W-1:0] wide_cnt;
		logic [TOTAL_W-1:0] emg_cnt;
	} state_t;

endpackage

`default_nettype wire

// File: hdl/carsw_stream_if.sv
// Valid/ready stream interface carrying one payload struct per request.
// Payload type is given at instantiation (see carsw_pkg).
`default_nettype none

interface carsw_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/carsw_regs.sv
// APB-style configuration registers for the auto-range switch.
// Depends on carsw_pkg.
`default_nettype none

module carsw_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [carsw_pkg::ADDR_W-1:0] paddr,
	input  wire logic [carsw_pkg::DATA_W-1:0] pwdata,
	output      logic [carsw_pkg::DATA_W-1:0] prdata,
	output      logic                         pready,
	output      carsw_pkg::cfg_t              cfg,
	output      carsw_pkg::cal_wr_t           cal_wr
);
	import carsw_pkg::*;

	cfg_t             cfg_q;
	logic [CAL_W-1:0] base_cal_q;
	reg_idx_t         idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_enable           <= RST_AUTO_EN;
			cfg_q.to_narrow_threshold   <= RST_NARROW_THR;
			cfg_q.to_wide_threshold     <= RST_WIDE_THR;
			cfg_q.emergency_threshold   <= RST_EMG_THR;
			cfg_q.low_runs_needed       <= RST_LOW_RUNS;
			cfg_q.high_runs_needed      <= RST_HIGH_RUNS;
			cfg_q.emergency_runs_needed <= RST_EMG_RUNS;
			base_cal_q                  <= RST_BASE_CAL;
		end else if (wr_en) begin
			unique case (idx)
				REG_AUTO_EN:    cfg_q.auto_enable           <= pwdata[0];
				REG_NARROW_THR: cfg_q.to_narrow_threshold   <= pwdata[MAG_W-1:0];
				REG_WIDE_THR:   cfg_q.to_wide_threshold     <= pwdata[MAG_W-1:0];
				REG_EMG_THR:    cfg_q.emergency_threshold   <= pwdata[MAG_W-1:0];
				REG_LOW_RUNS:   cfg_q.low_runs_needed       <= pwdata[RUN_W-1:0];
				REG_HIGH_RUNS:  cfg_q.high_runs_needed      <= pwdata[RUN_W-1:0];
				REG_EMG_RUNS:   cfg_q.emergency_runs_needed <= pwdata[RUN_W-1:0];
				REG_BASE_CAL:   base_cal_q                  <= pwdata[CAL_W-1:0];
				default: ;
			endcase
		end
	end

	// calibration write also reloads the live state in the core
	assign cal_wr.load  = wr_en && (idx == REG_BASE_CAL);
	assign cal_wr.value = pwdata[CAL_W-1:0];
	assign cfg          = cfg_q;

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_AUTO_EN:    prdata = DATA_W'(cfg_q.auto_enable);
			REG_NARROW_THR: prdata = DATA_W'(cfg_q.to_narrow_threshold);
			REG_WIDE_THR:   prdata = DATA_W'(cfg_q.to_wide_threshold);
			REG_EMG_THR:    prdata = DATA_W'(cfg_q.emergency_threshold);
			REG_LOW_RUNS:   prdata = DATA_W'(cfg_q.low_runs_needed);
			REG_HIGH_RUNS:  prdata = DATA_W'(cfg_q.high_runs_needed);
			REG_EMG_RUNS:   prdata = DATA_W'(cfg_q.emergency_runs_needed);
			REG_BASE_CAL:   prdata = DATA_W'(base_cal_q);
			default:        prdata = '0;
		endcase
	end
endmodule

`default_nettype wire

// File: hdl/carsw_core.sv
// Range decision datapath: input register, state, decision logic, result register.
// Depends on carsw_pkg and carsw_stream_if.
`default_nettype none

module carsw_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire carsw_pkg::cfg_t    cfg,
	input  wire carsw_pkg::cal_wr_t cal_wr,
	carsw_stream_if.sink            sample,
	carsw_stream_if.source          result
);
	import carsw_pkg::*;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                res_valid_q;
	result_t             res_q;
	state_t              st_q;
	state_t              nxt;
	event_t              ev;
	logic [SAMPLE_W-1:0] abs_full;
	logic [MAG_W-1:0]    mag;
	logic [RUN_W-1:0]    low_inc;
	logic [RUN_W-1:0]    high_inc;
	logic [RUN_W-1:0]    emg_inc;
	logic                x4_ok;
	logic                d4_ok;
	logic                adv;
	logic                fire;

	assign adv          = !res_valid_q || result.ready;
	assign sample.ready = !valid_s1 || adv;
	assign fire         = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1 <= sample.payload.current_sample;
		end
	end

	// magnitude, saturated (most negative code maps to the top)
	assign abs_full = sample_s1[SAMPLE_W-1] ? (~sample_s1 + 1'b1) : sample_s1;
	assign mag      = abs_full[SAMPLE_W-1] ? MAG_MAX : abs_full[MAG_W-1:0];

	assign low_inc  = (st_q.low_run == RUN_MAX) ? RUN_MAX : st_q.low_run + 1'b1;
	assign high_inc = (st_q.high_run == RUN_MAX) ? RUN_MAX : st_q.high_run + 1'b1;
	assign emg_inc  = (st_q.emg_run == RUN_MAX) ? RUN_MAX : st_q.emg_run + 1'b1;

	// x4 stays in 1..65535 only if nonzero and top two bits clear; /4 needs cal >= 4
	assign x4_ok = (st_q.cal_now[CAL_W-1:CAL_W-2] == 2'b00) && (st_q.cal_now != '0);
	assign d4_ok = |st_q.cal_now[CAL_W-1:2];

	always_comb begin
		nxt = st_q;
		ev  = EV_NONE;
		if (cfg.auto_enable) begin
			if (st_q.range_sel == RANGE_WIDE) begin
				if (mag < cfg.to_narrow_threshold) begin
					nxt.low_run = low_inc;
					if (low_inc >= cfg.low_runs_needed) begin
						if (x4_ok) begin
							nxt.cal_now    = {st_q.cal_now[CAL_W-3:0], 2'b00};
							nxt.range_sel  = RANGE_NARROW;
							nxt.narrow_cnt = st_q.narrow_cnt + 1'b1;
							nxt.low_run    = '0;
							nxt.high_run   = '0;
							nxt.emg_run    = '0;
							ev             = EV_NARROW;
						end else begin
							ev = EV_REJECT;
						end
					end
				end else begin
					nxt.low_run = '0;
				end
			end else begin
				priority if (mag > cfg.emergency_threshold) begin
					nxt.emg_run = emg_inc;
					if (emg_inc >= cfg.emergency_runs_needed) begin
						nxt.emg_cnt = st_q.emg_cnt + 1'b1;
						if (d4_ok) begin
							nxt.cal_now   = {2'b00, st_q.cal_now[CAL_W-1:2]};
							nxt.range_sel = RANGE_WIDE;
							nxt.wide_cnt  = st_q.wide_cnt + 1'b1;
							nxt.low_run   = '0;
							nxt.high_run  = '0;
							nxt.emg_run   = '0;
							ev            = EV_EMERG;
						end else begin
							ev = EV_REJECT;
						end
					end
				end else if (mag > cfg.to_wide_threshold) begin
					nxt.high_run = high_inc;
					nxt.emg_run  = '0;
					if (high_inc >= cfg.high_runs_needed) begin
						if (d4_ok) begin
							nxt.cal_now   = {2'b00, st_q.cal_now[CAL_W-1:2]};
							nxt.range_sel = RANGE_WIDE;
							nxt.wide_cnt  = st_q.wide_cnt + 1'b1;
							nxt.low_run   = '0;
							nxt.high_run  = '0;
							ev            = EV_WIDE;
						end else begin
							ev = EV_REJECT;
						end
					end
				end else begin
					nxt.high_run = '0;
					nxt.emg_run  = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.range_sel  <= RANGE_WIDE;
			st_q.cal_now    <= RST_BASE_CAL;
			st_q.low_run    <= '0;
			st_q.high_run   <= '0;
			st_q.emg_run    <= '0;
			st_q.narrow_cnt <= '0;
			st_q.wide_cnt   <= '0;
			st_q.emg_cnt    <= '0;
		end else if (cal_wr.load) begin
			st_q.range_sel <= RANGE_WIDE;
			st_q.cal_now   <= cal_wr.value;
			st_q.low_run   <= '0;
			st_q.high_run  <= '0;
			st_q.emg_run   <= '0;
		end else if (fire) begin
			st_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.adc_range           <= nxt.range_sel;
			res_q.shunt_cal_value     <= nxt.cal_now;
			res_q.switch_event        <= ev;
			res_q.narrow_switch_total <= nxt.narrow_cnt;
			res_q.wide_switch_total   <= nxt.wide_cnt;
			res_q.emergency_total     <= nxt.emg_cnt;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;
endmodule

`default_nettype wire

// File: hdl/current_auto_range_switch.sv
// Top level of the current auto-range switch: config registers and decision core.
// Depends on carsw_pkg, carsw_stream_if, carsw_regs, carsw_core and the defines header.
//
//   channel  dir  handshake              payload
//   sample   in   valid/ready            current_sample (s24)
//   result   out  valid/ready            range, cal, event, three totals
//   apb      in   psel/penable/pwrite    8 regs at 4*i, pready tied high
//
// A result passes from the input register through decision logic and state update into
// the result register. One request per cycle while the result is not stalled; the
// range/cal/run state loop closes through the state register alone.
// arst_n clears control state and loads register and calibration defaults.
// A stalled result holds in its register while one more sample is taken.
`default_nettype none
`include "current_auto_range_switch_defines.svh"

module current_auto_range_switch (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [carsw_pkg::ADDR_W-1:0] paddr,
	input  wire logic [carsw_pkg::DATA_W-1:0] pwdata,
	output      logic [carsw_pkg::DATA_W-1:0] prdata,
	output      logic                         pready,
	carsw_stream_if.sink                      sample,
	carsw_stream_if.source                    result
);
	import carsw_pkg::*;

	cfg_t    cfg;
	cal_wr_t cal_wr;
	logic    res_narrow_ev;
	logic    res_narrow_ok;
	logic    res_wide_ev;
	logic    res_wide_ok;

	carsw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cal_wr  (cal_wr)
	);

	carsw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cal_wr (cal_wr),
		.sample (sample),
		.result (result)
	);

	assign res_narrow_ev = result.valid && (result.payload.switch_event == EV_NARROW);
	assign res_narrow_ok = (result.payload.adc_range == RANGE_NARROW) &&
		(result.payload.shunt_cal_value[1:0] == 2'b00);
	assign res_wide_ev   = result.valid && ((result.payload.switch_event == EV_WIDE) ||
		(result.payload.switch_event == EV_EMERG));
	assign res_wide_ok   = (result.payload.adc_range == RANGE_WIDE);

	`CARSW_ASSERT(a_ready_when_empty, clk, arst_n, result.valid || sample.ready)
	`CARSW_ASSERT_IMPL(a_narrow_event, clk, arst_n, res_narrow_ev, res_narrow_ok)
	`CARSW_ASSERT_IMPL(a_wide_event, clk, arst_n, res_wide_ev, res_wide_ok)
endmodule

`default_nettype wire
